@@ rtl/evq_pkg.sv @@
// evq_pkg: shared types, constants and helpers of the masked event queue
// used by masked_event_queue and by the bench packages; depends on nothing
`default_nettype none

package evq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// operation codes
	localparam logic [1:0] OP_POST  = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// one stored event record
	typedef struct packed {
		logic [4:0]         kind;
		logic [31:0]        payload;
		logic [31:0]        stamp;
		logic signed [15:0] pos_h;
		logic signed [15:0] pos_v;
		logic [15:0]        mods;
	} evq_rec_t;

	localparam int REC_W = $bits(evq_rec_t);

	// types 16 and up share mask bit 15 (sign-extended mask)
	function automatic logic type_selected(input logic [4:0] kind, input logic [15:0] mask);
		logic [3:0] bit_idx;
		bit_idx = kind[4] ? 4'd15 : kind[3:0];
		return mask[bit_idx];
	endfunction

	// physical slot of a logical offset from the head
	function automatic ptr_t slot_at(input ptr_t head, input cnt_t off);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - PTR_W){1'b0}}, head} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	// pointer step forward with wrap
	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// pointer step back with wrap
	function automatic ptr_t ptr_dec(input ptr_t p);
		return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
	endfunction

endpackage

`default_nettype wire

@@ rtl/evq_ram.sv @@
// evq_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module evq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/masked_event_queue.sv @@
// masked_event_queue: event record queue with masked get, peek and flush
// depends on evq_pkg and evq_ram
`default_nettype none

// Usage
//   Command channel: an operation is transferred at a rising edge where start
//   is high and busy is low; op and the record fields are sampled there.
//   Result channel: done is high for exactly one cycle with status, the
//   returned record and fill_level; the receiver cannot stall it.
//   One operation is in flight at a time; busy is high until done is shown,
//   and a new command may be transferred in the cycle done is high.
// Steps of each operation (from the transfer edge to done)
//   post: the record is written at the tail if there is room, and done is shown
//   get/peek: entries are read and then checked against the type mask, from the
//   head up to and including the match; with no match the scan runs off the end;
//   a get that removes from mid-queue then moves each later entry down one place
//   flush: entries are read and checked from the head; each one picked by the type
//   mask is removed, with later entries moved down on a mid-queue removal, until
//   the stop mask ends it or it runs off the end
// All records sit in one ram with a registered read, and every
// read and every moved entry goes through its single read port.
// Reset clears head, tail and count; the ram contents are not cleared.

module masked_event_queue
	import evq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         op,
	input  wire logic [15:0]        type_mask,
	input  wire logic [15:0]        stop_mask,
	input  wire logic [4:0]         event_kind,
	input  wire logic [31:0]        payload,
	input  wire logic [31:0]        tick_stamp,
	input  wire logic signed [15:0] pos_h,
	input  wire logic signed [15:0] pos_v,
	input  wire logic [15:0]        mod_keys,
	output logic                    done,
	output logic [1:0]              status,
	output logic [4:0]              out_kind,
	output logic [31:0]             out_payload,
	output logic [31:0]             out_stamp,
	output logic signed [15:0]      out_h,
	output logic signed [15:0]      out_v,
	output logic [15:0]             out_mods,
	output logic [CNT_W-1:0]        fill_level
);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_POST     = 3'd1;
	localparam logic [2:0] S_FIND_RD  = 3'd2;
	localparam logic [2:0] S_FIND_CHK = 3'd3;
	localparam logic [2:0] S_SHIFT_RD = 3'd4;
	localparam logic [2:0] S_SHIFT_WR = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  op_q;
	logic [15:0] tmask_q;
	logic [15:0] smask_q;
	evq_rec_t    rec_q;
	ptr_t        head_q;
	ptr_t        tail_q;
	cnt_t        count_q;
	cnt_t        off_q;
	cnt_t        k_q;
	logic        done_q;
	logic [1:0]  status_q;
	evq_rec_t    out_q;
	cnt_t        fill_q;

	logic            ram_we;
	ptr_t            ram_waddr;
	logic [REC_W-1:0] ram_wdata;
	logic            ram_re;
	ptr_t            ram_raddr;
	logic [REC_W-1:0] ram_rdata;
	evq_rec_t        rd_rec;
	cnt_t            k_next;
	logic            not_full;
	logic            hit_t;
	logic            hit_s;

	assign rd_rec   = evq_rec_t'(ram_rdata);
	assign k_next   = k_q + 1'b1;
	assign not_full = count_q < CNT_W'(QUEUE_DEPTH);
	assign hit_t    = type_selected(rd_rec.kind, tmask_q);
	assign hit_s    = type_selected(rd_rec.kind, smask_q);

	// record store
	evq_ram #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = REC_W'(rec_q);
		ram_re    = 1'b0;
		ram_raddr = slot_at(head_q, off_q);
		unique case (state_q)
			S_POST: begin
				ram_we = not_full;
			end
			S_FIND_RD: begin
				ram_re = off_q < count_q;
			end
			S_SHIFT_RD: begin
				ram_re    = k_next < count_q;
				ram_raddr = slot_at(head_q, k_next);
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_at(head_q, k_q);
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	// command latch
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q    <= op;
			tmask_q <= type_mask;
			smask_q <= stop_mask;
			rec_q   <= '{kind: event_kind, payload: payload, stamp: tick_stamp,
				pos_h: pos_h, pos_v: pos_v, mods: mod_keys};
		end
	end

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			off_q    <= '0;
			k_q      <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			fill_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						off_q   <= '0;
						state_q <= (op == OP_POST) ? S_POST : S_FIND_RD;
					end
				end
				S_POST: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (not_full) begin
						tail_q   <= ptr_inc(tail_q);
						count_q  <= count_q + 1'b1;
						fill_q   <= count_q + 1'b1;
						status_q <= ST_OK;
					end else begin
						fill_q   <= count_q;
						status_q <= ST_FULL;
					end
				end
				S_FIND_RD: begin
					if (off_q < count_q) begin
						state_q <= S_FIND_CHK;
					end else begin
						// scan ran off the end
						done_q   <= 1'b1;
						fill_q   <= count_q;
						status_q <= (op_q == OP_FLUSH) ? ST_OK : ST_NONE;
						state_q  <= S_IDLE;
					end
				end
				S_FIND_CHK: begin
					if (op_q == OP_FLUSH) begin
						if (hit_s) begin
							done_q   <= 1'b1;
							fill_q   <= count_q;
							status_q <= ST_OK;
							state_q  <= S_IDLE;
						end else if (hit_t) begin
							if (off_q == '0) begin
								head_q  <= ptr_inc(head_q);
								count_q <= count_q - 1'b1;
								state_q <= S_FIND_RD;
							end else begin
								k_q     <= off_q;
								state_q <= S_SHIFT_RD;
							end
						end else begin
							off_q   <= off_q + 1'b1;
							state_q <= S_FIND_RD;
						end
					end else if (hit_t) begin
						status_q <= ST_OK;
						if (op_q == OP_PEEK) begin
							done_q  <= 1'b1;
							fill_q  <= count_q;
							state_q <= S_IDLE;
						end else if (off_q == '0) begin
							head_q  <= ptr_inc(head_q);
							count_q <= count_q - 1'b1;
							fill_q  <= count_q - 1'b1;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q     <= off_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						off_q   <= off_q + 1'b1;
						state_q <= S_FIND_RD;
					end
				end
				S_SHIFT_RD: begin
					if (k_next < count_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						// gap closed, drop the last slot
						tail_q  <= ptr_dec(tail_q);
						count_q <= count_q - 1'b1;
						if (op_q == OP_FLUSH) begin
							state_q <= S_FIND_RD;
						end else begin
							done_q   <= 1'b1;
							fill_q   <= count_q - 1'b1;
							status_q <= ST_OK;
							state_q  <= S_IDLE;
						end
					end
				end
				S_SHIFT_WR: begin
					k_q     <= k_next;
					state_q <= S_SHIFT_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// returned record: captured on a get or peek match, zero otherwise
	always_ff @(posedge clk) begin
		if (state_q == S_FIND_CHK && op_q != OP_FLUSH && hit_t) begin
			out_q <= rd_rec;
		end else if (state_q == S_IDLE && start) begin
			out_q <= '0;
		end
	end

	// result ports
	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign out_kind    = out_q.kind;
	assign out_payload = out_q.payload;
	assign out_stamp   = out_q.stamp;
	assign out_h       = out_q.pos_h;
	assign out_v       = out_q.pos_v;
	assign out_mods    = out_q.mods;
	assign fill_level  = fill_q;

endmodule

`default_nettype wire

@@ dv/evq_tb_pkg.sv @@
// evq_tb_pkg: command and result records plus the scoreboard of the event queue bench
// depends on evq_pkg for the record layout, operation and status codes
package evq_tb_pkg;
	import evq_pkg::*;

	// one command as driven on the input ports
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] type_mask;
		logic [15:0] stop_mask;
		evq_rec_t    rec;
	} evq_cmd_t;

	// one result as shown on the output ports
	typedef struct packed {
		logic [1:0] status;
		evq_rec_t   rec;
		cnt_t       fill;
	} evq_res_t;

	class evq_scoreboard;
		evq_rec_t held[$];   // queued records, oldest first
		evq_res_t owed[$];   // results still to come, oldest first
		int       errors = 0;

		// types 16 and up all look at mask bit 15
		function bit selects(logic [4:0] kind, logic [15:0] mask);
			return mask[kind > 5'd15 ? 4'd15 : kind[3:0]];
		endfunction

		// apply one command to the mirrored queue and return what the block must show
		function evq_res_t apply_command(evq_cmd_t c);
			evq_res_t r;
			int       idx;
			int       k;
			r = '0;
			r.status = ST_OK;
			case (c.op) inside
				OP_POST: begin
					if (held.size() >= QUEUE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						held.push_back(c.rec);
					end
				end
				OP_GET, OP_PEEK: begin
					idx = -1;
					for (k = 0; k < held.size(); k++) begin
						if (selects(held[k].kind, c.type_mask)) begin
							idx = k;
							break;
						end
					end
					if (idx < 0) begin
						r.status = ST_NONE;
					end else begin
						r.rec = held[idx];
						if (c.op == OP_GET) begin
							held.delete(idx);
						end
					end
				end
				default: begin
					// flush: stop selection wins over removal on the same record
					k = 0;
					while (k < held.size()) begin
						if (selects(held[k].kind, c.stop_mask)) begin
							break;
						end
						if (selects(held[k].kind, c.type_mask)) begin
							held.delete(k);
						end else begin
							k++;
						end
					end
				end
			endcase
			r.fill = cnt_t'(held.size());
			return r;
		endfunction

		// called once per accepted command transfer
		function void note_command(evq_cmd_t c);
			owed.push_back(apply_command(c));
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
				errors++;
			end
		endfunction

		// called once per result strobe
		function void check_result(evq_res_t seen);
			evq_res_t want;
			if (owed.size() == 0) begin
				$display("%0t: result with no command outstanding, got status %0h",
					$time, seen.status);
				errors++;
				return;
			end
			want = owed.pop_front();
			compare_field("status", 32'(want.status), 32'(seen.status));
			compare_field("out_kind", 32'(want.rec.kind), 32'(seen.rec.kind));
			compare_field("out_payload", want.rec.payload, seen.rec.payload);
			compare_field("out_stamp", want.rec.stamp, seen.rec.stamp);
			compare_field("out_h", 32'(want.rec.pos_h), 32'(seen.rec.pos_h));
			compare_field("out_v", 32'(want.rec.pos_v), 32'(seen.rec.pos_v));
			compare_field("out_mods", 32'(want.rec.mods), 32'(seen.rec.mods));
			compare_field("fill_level", 32'(want.fill), 32'(seen.fill));
		endfunction
	endclass

endpackage

@@ dv/tb_masked_event_queue.sv @@
// tb_masked_event_queue: self-checking bench for masked_event_queue, directed then random
// depends on evq_pkg, evq_tb_pkg and the masked_event_queue rtl
module tb_masked_event_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import evq_pkg::*;
	import evq_tb_pkg::*;

	localparam int STALL_LIMIT     = 20000;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int TAIL_CYCLES     = 16;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         op;
	logic [15:0]        type_mask;
	logic [15:0]        stop_mask;
	logic [4:0]         event_kind;
	logic [31:0]        payload;
	logic [31:0]        tick_stamp;
	logic signed [15:0] pos_h;
	logic signed [15:0] pos_v;
	logic [15:0]        mod_keys;
	logic               done;
	logic [1:0]         status;
	logic [4:0]         out_kind;
	logic [31:0]        out_payload;
	logic [31:0]        out_stamp;
	logic signed [15:0] out_h;
	logic signed [15:0] out_v;
	logic [15:0]        out_mods;
	logic [CNT_W-1:0]   fill_level;

	evq_scoreboard sb = new;

	masked_event_queue i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.type_mask   (type_mask),
		.stop_mask   (stop_mask),
		.event_kind  (event_kind),
		.payload     (payload),
		.tick_stamp  (tick_stamp),
		.pos_h       (pos_h),
		.pos_v       (pos_v),
		.mod_keys    (mod_keys),
		.done        (done),
		.status      (status),
		.out_kind    (out_kind),
		.out_payload (out_payload),
		.out_stamp   (out_stamp),
		.out_h       (out_h),
		.out_v       (out_v),
		.out_mods    (out_mods),
		.fill_level  (fill_level)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hold a command on the ports until its transfer, then log it
	task automatic issue(input evq_cmd_t c);
		op         <= c.op;
		type_mask  <= c.type_mask;
		stop_mask  <= c.stop_mask;
		event_kind <= c.rec.kind;
		payload    <= c.rec.payload;
		tick_stamp <= c.rec.stamp;
		pos_h      <= c.rec.pos_h;
		pos_v      <= c.rec.pos_v;
		mod_keys   <= c.rec.mods;
		start      <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c);
	endtask

	// one command, then maybe a gap of random length
	task automatic send(input evq_cmd_t c, input int idle_pct);
		issue(c);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(7) == 0) begin
				repeat ($urandom_range(40, 5)) @(posedge clk);
			end else begin
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end
		end
	endtask

	// sender holds off until every outstanding result has been seen
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic evq_cmd_t make_cmd(logic [1:0] o, logic [15:0] tmask,
		logic [15:0] smask, logic [4:0] kind, logic [31:0] msg, logic [31:0] stamp,
		logic [15:0] h, logic [15:0] v, logic [15:0] mods);
		evq_cmd_t c;
		c.op          = o;
		c.type_mask   = tmask;
		c.stop_mask   = smask;
		c.rec.kind    = kind;
		c.rec.payload = msg;
		c.rec.stamp   = stamp;
		c.rec.pos_h   = h;
		c.rec.pos_v   = v;
		c.rec.mods    = mods;
		return c;
	endfunction

	// masks mix single bits, the high-type bit, sparse and dense patterns
	function automatic logic [15:0] random_mask();
		case ($urandom_range(5))
			0: return 16'hffff;
			1: return 16'h0001 << $urandom_range(15);
			2: return 16'h8000;
			3: return 16'($urandom & $urandom & $urandom);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic evq_cmd_t random_command(int post_pct);
		evq_cmd_t c;
		int       roll;
		c.rec.kind    = 5'($urandom);
		c.rec.payload = $urandom;
		c.rec.stamp   = $urandom;
		c.rec.pos_h   = 16'($urandom);
		c.rec.pos_v   = 16'($urandom);
		c.rec.mods    = 16'($urandom);
		c.type_mask   = random_mask();
		c.stop_mask   = ($urandom_range(1) == 0) ? 16'h0000 : random_mask();
		roll = $urandom_range(99);
		if (roll < post_pct) begin
			c.op = OP_POST;
		end else begin
			roll = $urandom_range(9);
			c.op = (roll < 4) ? OP_GET : (roll < 7) ? OP_PEEK : OP_FLUSH;
		end
		return c;
	endfunction

	// random segments: fill to full, post-heavy, balanced, drain-heavy
	task automatic random_phase(input int idle_pct);
		int sent;
		int run;
		int post_pct;
		sent = 0;
		while (sent < ITEMS_PER_PHASE) begin
			case ($urandom_range(3))
				0: begin
					// fill up, then two posts into a full queue
					run = QUEUE_DEPTH - sb.held.size() + 2;
					post_pct = 100;
				end
				1: begin
					run = $urandom_range(40, 10);
					post_pct = 80;
				end
				2: begin
					run = $urandom_range(40, 10);
					post_pct = 50;
				end
				default: begin
					run = $urandom_range(40, 10);
					post_pct = 25;
				end
			endcase
			repeat (run) send(random_command(post_pct), idle_pct);
			sent += run;
		end
		drain_results();
	endtask

	// check every result strobe
	always @(posedge clk) begin : result_watch
		evq_res_t seen;
		if (arst_n === 1'b1 && done !== 1'b0) begin
			seen.status      = status;
			seen.rec.kind    = out_kind;
			seen.rec.payload = out_payload;
			seen.rec.stamp   = out_stamp;
			seen.rec.pos_h   = out_h;
			seen.rec.pos_v   = out_v;
			seen.rec.mods    = out_mods;
			seen.fill        = fill_level;
			sb.check_result(seen);
		end
	end

	// give up after a long stretch with no transfer and no result
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		start      <= 1'b0;
		arst_n     <= 1'b0;
		op         <= OP_POST;
		type_mask  <= '0;
		stop_mask  <= '0;
		event_kind <= '0;
		payload    <= '0;
		tick_stamp <= '0;
		pos_h      <= '0;
		pos_v      <= '0;
		mod_keys   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: get and peek find nothing, flush does nothing
		send(make_cmd(OP_GET, 16'hffff, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_PEEK, 16'hffff, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_FLUSH, 16'hffff, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		// field extremes and the kinds around the shared high bit
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd0, 32'h0, 32'h0,
			16'h8000, 16'h7fff, 16'h0000), 0);
		send(make_cmd(OP_POST, 16'hffff, 16'hffff, 5'd31, 32'hffff_ffff, 32'hffff_ffff,
			16'h7fff, 16'h8000, 16'hffff), 0);
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd15, 32'ha5a5_5a5a, 32'h0000_1234,
			16'hffff, 16'h0001, 16'h5555), 0);
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd16, 32'h1234_5678, 32'h8000_0000,
			16'h0001, 16'hffff, 16'haaaa), 0);
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd1, 32'h8000_0001, 32'h7fff_ffff,
			16'h0100, 16'hfe00, 16'h0f0f), 0);
		// mask with no bits, then the high bit picks the oldest of kinds 15 and up
		send(make_cmd(OP_PEEK, 16'h0000, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_PEEK, 16'h8000, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		// removal from mid-queue, from the tail, from the head
		send(make_cmd(OP_GET, 16'h8000, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_GET, 16'h0002, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_GET, 16'h0001, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd2, 32'h0000_0002, 32'h10, 16'h2,
			16'h2, 16'h2), 0);
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd2, 32'h0000_0003, 32'h11, 16'h3,
			16'h3, 16'h3), 0);
		send(make_cmd(OP_POST, 16'h0000, 16'h0000, 5'd3, 32'h0000_0004, 32'h12, 16'h4,
			16'h4, 16'h4), 0);
		// back-to-back mid-queue removals keep the scan in place
		send(make_cmd(OP_FLUSH, 16'h0004, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		// stop hits the head at once
		send(make_cmd(OP_FLUSH, 16'h8008, 16'h8000, 5'd0, '0, '0, '0, '0, '0), 0);
		// record picked by both stop and flush masks stays
		send(make_cmd(OP_FLUSH, 16'h0008, 16'h0008, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_FLUSH, 16'hffff, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		send(make_cmd(OP_GET, 16'hffff, 16'h0000, 5'd0, '0, '0, '0, '0, '0), 0);
		drain_results();

		// sender idles often, then almost always, then never
		random_phase(28);
		random_phase(82);
		random_phase(0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ masked_event_queue.f @@
rtl/evq_pkg.sv
rtl/evq_ram.sv
rtl/masked_event_queue.sv
dv/evq_tb_pkg.sv
dv/tb_masked_event_queue.sv
